// ===== rtl/core/least_used_frame_evictor_unit_assert.svh =====
// Assertion macros for the evictor port checker
`ifndef LEAST_USED_FRAME_EVICTOR_UNIT_ASSERT_SVH
`define LEAST_USED_FRAME_EVICTOR_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define LFUE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, held off during reset
`define LFUE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/core/lfue_pkg.sv =====
// Package: widths, codes and types of the least-used frame evictor
`default_nettype none

package lfue_pkg;

    localparam int LFUE_FRAMES       = 32;
    localparam int LFUE_COUNTER_BITS = 16;
    localparam int MAX_RESULTS       = 32;
    localparam int STEP_W            = $clog2(MAX_RESULTS + 1);

    localparam int REQ_TYPE_W = 2;
    localparam int FRAME_W    = 5;
    localparam int CNT_IN_W   = 16;
    localparam int COUNT_W    = 6;
    localparam int THR_W      = 6;

    localparam logic [THR_W-1:0] THR_RESET = 6'd24;

    localparam logic [REQ_TYPE_W-1:0] REQ_SET_COUNTER = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_SET_IN_USE  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_EVICT       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } lfue_state_t;

    typedef struct packed {
        logic wr_en;
        logic clr_en;
    } lfue_cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfue_req_if.sv =====
// Request channel: counter writes, in-use writes and evict commands
`default_nettype none

interface lfue_req_if;
    import lfue_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [FRAME_W-1:0]    frame_index;
    logic [CNT_IN_W-1:0]   counter_value;
    logic [COUNT_W-1:0]    in_use_value;

    modport source (output valid, req_type, frame_index, counter_value, in_use_value,
                    input ready);
    modport sink   (input valid, req_type, frame_index, counter_value, in_use_value,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfue_res_if.sv =====
// Result channel: one transaction per evicted frame
`default_nettype none

interface lfue_res_if;
    import lfue_pkg::*;

    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] evicted_frame;
    logic               none_in_use;
    logic [COUNT_W-1:0] remaining_count;
    logic               last_eviction;

    modport source (output valid, evicted_frame, none_in_use, remaining_count,
                    last_eviction, input ready);
    modport sink   (input valid, evicted_frame, none_in_use, remaining_count,
                    last_eviction, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfue_cfg_if.sv =====
// Configuration write channel for the occupancy threshold
`default_nettype none

interface lfue_cfg_if;
    import lfue_pkg::*;

    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfue_cell.sv =====
// One frame cell: usage counter plus one stage of the minimum-search chain
`default_nettype none

module lfue_cell #(
    parameter int COUNTER_BITS = 16,
    parameter int IDX_W        = 5,
    parameter int INDEX        = 0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  lfue_pkg::lfue_cell_ctl_t     ctl,
    input  wire [COUNTER_BITS-1:0]       wr_data,
    input  wire                          in_valid,
    input  wire                          in_found,
    input  wire [COUNTER_BITS-1:0]       in_min,
    input  wire [IDX_W-1:0]              in_idx,
    output logic                         out_valid,
    output logic                         out_found,
    output logic [COUNTER_BITS-1:0]      out_min,
    output logic [IDX_W-1:0]             out_idx
);
    import lfue_pkg::*;

    logic [COUNTER_BITS-1:0] counter_reg, counter_next;
    logic                    valid_reg;
    logic                    found_reg;
    logic [COUNTER_BITS-1:0] min_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    take;

    // strict less-than keeps the lower index on ties
    assign take = (counter_reg != '0) && (!in_found || (counter_reg < in_min));

    always_comb
    begin
        counter_next = counter_reg;
        priority if (ctl.wr_en)
        begin
            counter_next = wr_data;
        end
        else if (ctl.clr_en)
        begin
            counter_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            valid_reg   <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            found_reg <= in_found | take;
            min_reg   <= take ? counter_reg : in_min;
            idx_reg   <= take ? IDX_W'(INDEX) : in_idx;
        end
    end

    assign out_valid = valid_reg;
    assign out_found = found_reg;
    assign out_min   = min_reg;
    assign out_idx   = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/core/least_used_frame_evictor_unit.sv =====
// An evict request starts a scan: the token passes down the row of frame cells, the
// victim is registered, then cleared and emitted once the result register is free.
// Each further result of a run repeats this pass of the scan token and emit.
// Counter and in-use writes are registered; requests are taken only between runs.
// Reset: all usage counters and the in-use count clear, threshold returns to 24.
`default_nettype none

module least_used_frame_evictor_unit #(
    parameter int FRAMES       = lfue_pkg::LFUE_FRAMES,
    parameter int COUNTER_BITS = lfue_pkg::LFUE_COUNTER_BITS
) (
    input  wire         clk,
    input  wire         rst_n,
    lfue_req_if.sink    req,
    lfue_res_if.source  res,
    lfue_cfg_if.sink    cfg
);
    import lfue_pkg::*;

    localparam int IDX_W = $clog2(FRAMES);

    lfue_state_t             state_reg, state_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [THR_W-1:0]        thr_reg;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [IDX_W-1:0]        victim_reg;
    logic                    none_reg;
    logic                    start_reg, start_next;

    logic                    out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]      out_frame_reg;
    logic                    out_none_reg;
    logic [COUNT_W-1:0]      out_rem_reg;
    logic                    out_last_reg;

    logic                    req_fire;
    logic                    emit_fire;
    logic                    run_ok;
    logic                    step_last;
    logic [COUNT_W-1:0]      count_dec;
    logic [COUNT_W-1:0]      in_use_sat;
    logic [COUNTER_BITS+CNT_IN_W-1:0] wr_wide;
    logic [COUNTER_BITS-1:0] wr_data;
    logic [IDX_W+FRAME_W-1:0] victim_wide;

    logic [FRAMES:0]         chain_valid;
    logic [FRAMES:0]         chain_found;
    logic [COUNTER_BITS-1:0] chain_min [FRAMES+1];
    logic [IDX_W-1:0]        chain_idx [FRAMES+1];

    assign req_fire  = req.valid && req.ready;
    assign count_dec = count_reg - COUNT_W'(1);
    assign run_ok    = (count_reg != '0) && (count_reg >= thr_reg);
    assign step_last = !((count_dec != '0) && (count_dec >= thr_reg) &&
                         (step_reg != STEP_W'(MAX_RESULTS - 1)));
    assign in_use_sat = (7'(req.in_use_value) > 7'(FRAMES)) ? COUNT_W'(FRAMES)
                                                             : req.in_use_value;
    assign wr_wide     = {{COUNTER_BITS{1'b0}}, req.counter_value};
    assign wr_data     = wr_wide[COUNTER_BITS-1:0];
    assign victim_wide = {{FRAME_W{1'b0}}, victim_reg};

    // scan chain head
    assign chain_valid[0] = start_reg;
    assign chain_found[0] = 1'b0;
    assign chain_min[0]   = '0;
    assign chain_idx[0]   = '0;

    for (genvar k = 0; k < FRAMES; k++)
    begin : g_cell
        lfue_cell_ctl_t ctl;

        assign ctl.wr_en  = req_fire && (req.req_type == REQ_SET_COUNTER) &&
                            ((IDX_W + FRAME_W)'(req.frame_index) == (IDX_W + FRAME_W)'(k));
        assign ctl.clr_en = emit_fire && (victim_reg == IDX_W'(k));

        lfue_cell #(
            .COUNTER_BITS (COUNTER_BITS),
            .IDX_W        (IDX_W),
            .INDEX        (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr_data   (wr_data),
            .in_valid  (chain_valid[k]),
            .in_found  (chain_found[k]),
            .in_min    (chain_min[k]),
            .in_idx    (chain_idx[k]),
            .out_valid (chain_valid[k+1]),
            .out_found (chain_found[k+1]),
            .out_min   (chain_min[k+1]),
            .out_idx   (chain_idx[k+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_EVICT) && run_ok)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain_valid[FRAMES])
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = step_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        req.ready  = 1'b0;
        emit_fire  = 1'b0;
        start_next = 1'b0;
        step_next  = step_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                // ready is high here, so valid alone marks a transaction
                if (req.valid)
                begin
                    if (req.req_type == REQ_SET_IN_USE)
                    begin
                        count_next = in_use_sat;
                    end
                    if ((req.req_type == REQ_EVICT) && run_ok)
                    begin
                        start_next = 1'b1;
                        step_next  = '0;
                    end
                end
            end
            ST_SCAN:
            begin
            end
            ST_EMIT:
            begin
                emit_fire = !out_valid_reg || res.ready;
                if (emit_fire)
                begin
                    count_next = count_dec;
                    step_next  = step_reg + STEP_W'(1);
                    start_next = !step_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            thr_reg       <= THR_RESET;
            step_reg      <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                thr_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SCAN) && chain_valid[FRAMES])
        begin
            victim_reg <= chain_found[FRAMES] ? chain_idx[FRAMES] : '0;
            none_reg   <= !chain_found[FRAMES];
        end
        if (emit_fire)
        begin
            out_frame_reg <= victim_wide[FRAME_W-1:0];
            out_none_reg  <= none_reg;
            out_rem_reg   <= count_dec;
            out_last_reg  <= step_last;
        end
    end

    assign cfg.ready           = 1'b1;
    assign res.valid           = out_valid_reg;
    assign res.evicted_frame   = out_frame_reg;
    assign res.none_in_use     = out_none_reg;
    assign res.remaining_count = out_rem_reg;
    assign res.last_eviction   = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lfue_checker.sv =====
// Port-level checks on the evictor, bound to the top level
`default_nettype none

`include "least_used_frame_evictor_unit_assert.svh"

module lfue_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           req_valid,
    input wire                           req_ready,
    input wire                           res_valid,
    input wire                           res_ready,
    input wire [lfue_pkg::FRAME_W-1:0]   res_frame,
    input wire                           res_none,
    input wire [lfue_pkg::COUNT_W-1:0]   res_rem,
    input wire                           res_last
);
    import lfue_pkg::*;

    // a stalled result holds its payload
    `LFUE_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res_frame) && $stable(res_none) && $stable(res_rem) && $stable(res_last))

    // an empty table always reports frame 0
    `LFUE_ASSERT_NOW(a_none_frame0, clk, rst_n, res_valid && res_none, res_frame == '0)

    // no request is taken while a run still has results to come
    `LFUE_ASSERT_NOW(a_run_blocks_req, clk, rst_n, res_valid && !res_last, !req_ready)

    // a result never appears the cycle after a request is taken
    `LFUE_ASSERT_NEXT(a_no_instant_res, clk, rst_n, req_valid && req_ready, !$rose(res_valid))

endmodule

bind least_used_frame_evictor_unit lfue_checker u_lfue_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_frame (res.evicted_frame),
    .res_none  (res.none_in_use),
    .res_rem   (res.remaining_count),
    .res_last  (res.last_eviction)
);

`default_nettype wire

// ===== sim/least_used_frame_evictor_unit_tb.sv =====
// Testbench for the least-used frame evictor: scoreboard against an LFU predictor
`timescale 1ns / 1ps

module least_used_frame_evictor_unit_tb;
    import lfue_pkg::*;

    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 600;
    localparam int ITEM_TARGET = 220;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [FRAME_W-1:0]    frame;
        logic [CNT_IN_W-1:0]   count_val;
        logic [COUNT_W-1:0]    in_use;
    } request_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               none;
        logic [COUNT_W-1:0] remaining;
        logic               last;
    } eviction_t;

    logic clk = 1'b0;
    logic rst_n;

    lfue_req_if req_bus();
    lfue_res_if res_bus();
    lfue_cfg_if cfg_bus();

    least_used_frame_evictor_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    always #5 clk = ~clk;

    // predicted block state
    logic [LFUE_COUNTER_BITS-1:0] frame_use [LFUE_FRAMES] = '{default: '0};
    logic [COUNT_W-1:0]           frames_in_use = '0;
    logic [THR_W-1:0]             occ_threshold = THR_RESET;

    request_t  pending_requests [$];
    eviction_t expected_evictions [$];

    int   failures = 0;
    int   items_total = 0;
    int   cycle_cnt = 0;
    int   hold_left = 0;
    logic req_taken = 1'b0;
    logic random_phase = 1'b0;
    logic hold_armed = 1'b0;
    logic hold_done = 1'b0;
    logic steady;

    // stretch with no idling on either side
    assign steady = (cycle_cnt % 8000) >= 5000;

    task automatic apply_request(input request_t r, output int produced);
        int        k;
        int        best;
        logic      found;
        eviction_t e;
        produced = 0;
        case (r.kind)
            REQ_SET_COUNTER: frame_use[r.frame] = r.count_val;
            REQ_SET_IN_USE:  frames_in_use = (r.in_use > COUNT_W'(LFUE_FRAMES))
                                             ? COUNT_W'(LFUE_FRAMES) : r.in_use;
            REQ_EVICT: begin
                while (produced < MAX_RESULTS && frames_in_use != 0
                       && frames_in_use >= occ_threshold) begin
                    best  = 0;
                    found = 1'b0;
                    for (k = 0; k < LFUE_FRAMES; k++) begin
                        if (frame_use[k] != 0 && (!found || frame_use[k] < frame_use[best])) begin
                            best  = k;
                            found = 1'b1;
                        end
                    end
                    frame_use[best] = '0;
                    frames_in_use   = frames_in_use - COUNT_W'(1);
                    produced++;
                    e.frame     = FRAME_W'(best);
                    e.none      = !found;
                    e.remaining = frames_in_use;
                    e.last      = !(produced < MAX_RESULTS && frames_in_use != 0
                                    && frames_in_use >= occ_threshold);
                    expected_evictions.push_back(e);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            failures++;
            $display("%0t: %s wrong, expected %0d actual %0d", $time, label, want, got);
        end
    endtask

    task automatic queue_request(input logic [REQ_TYPE_W-1:0] kind, input logic [FRAME_W-1:0] frame,
                                 input logic [CNT_IN_W-1:0] cval, input logic [COUNT_W-1:0] inuse);
        request_t r;
        r.kind      = kind;
        r.frame     = frame;
        r.count_val = cval;
        r.in_use    = inuse;
        pending_requests.push_back(r);
        if (kind != REQ_UNUSED)
            items_total++;
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // all requests taken, all evictions seen, then let the scan finish
    task automatic settle();
        while (pending_requests.size() != 0 || req_bus.valid || expected_evictions.size() != 0)
            @(posedge clk);
        repeat (LFUE_FRAMES + 8) @(posedge clk);
    endtask

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("least_used_frame_evictor_unit: mismatch");
            $finish;
        end
    end

    always @(negedge clk) begin : request_driver
        request_t nxt;
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
        end
        else if (!req_bus.valid || req_taken) begin
            if (pending_requests.size() == 0 || (!steady && $urandom_range(99) < 25)) begin
                req_bus.valid <= 1'b0;
            end
            else begin
                nxt = pending_requests.pop_front();
                req_bus.valid         <= 1'b1;
                req_bus.req_type      <= nxt.kind;
                req_bus.frame_index   <= nxt.frame;
                req_bus.counter_value <= nxt.count_val;
                req_bus.in_use_value  <= nxt.in_use;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
            res_bus.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 25);
    end

    // one long receiver hold-off once a run is under way
    always @(negedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk) begin : monitor
        eviction_t want;
        request_t  r;
        int        produced;
        req_taken <= req_bus.valid && req_bus.ready;
        if (rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_evictions.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected eviction, expected none actual frame %0d",
                             $time, res_bus.evicted_frame);
                end
                else begin
                    want = expected_evictions.pop_front();
                    check_field("evicted_frame", int'(want.frame), int'(res_bus.evicted_frame));
                    check_field("none_in_use", int'(want.none), int'(res_bus.none_in_use));
                    check_field("remaining_count", int'(want.remaining),
                                int'(res_bus.remaining_count));
                    check_field("last_eviction", int'(want.last), int'(res_bus.last_eviction));
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
                occ_threshold = cfg_bus.data;
            if (req_bus.valid && req_bus.ready) begin
                r.kind      = req_bus.req_type;
                r.frame     = req_bus.frame_index;
                r.count_val = req_bus.counter_value;
                r.in_use    = req_bus.in_use_value;
                apply_request(r, produced);
                if (random_phase && produced > 0)
                    hold_armed <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int                 phase_goal;
        int                 n;
        logic [THR_W-1:0]   thr;
        logic [COUNT_W-1:0] lo;
        logic [COUNT_W-1:0] inuse;
        req_bus.valid         = 1'b0;
        req_bus.req_type      = REQ_SET_COUNTER;
        req_bus.frame_index   = '0;
        req_bus.counter_value = '0;
        req_bus.in_use_value  = '0;
        res_bus.ready         = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.data          = '0;
        rst_n                 = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset threshold: empty evict, ignored type, saturation, ties, all-zero default
        queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
        queue_request(REQ_UNUSED, $urandom, $urandom, $urandom);
        queue_request(REQ_SET_IN_USE, $urandom, $urandom, 6'd63);
        queue_request(REQ_SET_COUNTER, 5'd31, 16'hFFFF, $urandom);
        queue_request(REQ_SET_COUNTER, 5'd5, 16'h0001, $urandom);
        queue_request(REQ_SET_COUNTER, 5'd9, 16'h0001, $urandom);
        queue_request(REQ_SET_COUNTER, 5'd0, 16'h8000, $urandom);
        queue_request(REQ_SET_COUNTER, 5'd17, 16'h0000, $urandom);
        queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
        queue_request(REQ_SET_IN_USE, $urandom, $urandom, 6'd0);
        queue_request(REQ_SET_IN_USE, $urandom, $urandom, 6'd24);
        queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
        queue_request(REQ_SET_IN_USE, $urandom, $urandom, 6'd23);
        queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
        settle();

        write_threshold(6'd32);
        queue_request(REQ_SET_IN_USE, $urandom, $urandom, 6'd32);
        queue_request(REQ_SET_COUNTER, 5'd12, 16'h00FF, $urandom);
        queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
        settle();

        // zero threshold: run ends when the count reaches zero
        write_threshold(6'd0);
        queue_request(REQ_SET_COUNTER, 5'd31, 16'hFFFE, $urandom);
        queue_request(REQ_SET_COUNTER, 5'd30, 16'hFFFE, $urandom);
        queue_request(REQ_SET_IN_USE, $urandom, $urandom, 6'd32);
        queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
        settle();

        write_threshold(6'd63);
        queue_request(REQ_SET_IN_USE, $urandom, $urandom, 6'd32);
        queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
        settle();

        write_threshold(6'd1);
        queue_request(REQ_SET_IN_USE, $urandom, $urandom, 6'd5);
        queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
        settle();

        random_phase = 1'b1;
        while (items_total < ITEM_TARGET) begin
            case ($urandom_range(9))
                0:       thr = 6'd0;
                1:       thr = $urandom_range(33, 63);
                2, 3:    thr = $urandom_range(1, 15);
                default: thr = $urandom_range(16, 32);
            endcase
            write_threshold(thr);
            lo = (thr > 32) ? 6'd30 : ((thr > 2) ? thr - 2 : 6'd0);
            phase_goal = items_total + 30;
            while (items_total < phase_goal) begin
                n = $urandom_range(99);
                if (n < 70) begin
                    repeat ($urandom_range(0, 4))
                        queue_request(REQ_SET_COUNTER, $urandom_range(0, 31),
                                      ($urandom_range(3) == 0) ? $urandom_range(1, 4)
                                                               : $urandom_range(0, 65535),
                                      $urandom);
                    inuse = ($urandom_range(9) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(lo, 32);
                    queue_request(REQ_SET_IN_USE, $urandom, $urandom, inuse);
                    queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
                end
                else if (n < 85) begin
                    // evict without a fresh count
                    queue_request(REQ_EVICT, $urandom, $urandom, $urandom);
                end
                else begin
                    queue_request($urandom_range(0, 3), $urandom, $urandom, $urandom);
                end
            end
            settle();
        end

        if (failures == 0)
            $display("least_used_frame_evictor_unit: match");
        else
            $display("least_used_frame_evictor_unit: mismatch");
        $finish;
    end

endmodule
